// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by hilbert_fir_envelope, the RTL of the envelope detector.
// Standalone header; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HFE_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("hfe assertion failed");
`define HFE_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("hfe forbidden condition seen");
`else
`define HFE_ASSERT(label, clk, rstn, prop)
`define HFE_NEVER(label, clk, rstn, expr)
`endif
`endif

// ===== rtl/core/hfe_pkg.sv =====
// Types and constants of the Hilbert FIR envelope detector.
// No dependencies; imported by hilbert_fir_envelope.
`default_nettype none

package hfe_pkg;

    localparam int MAX_TAPS_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int CIDX_W   = 6;
    localparam int HALF_W   = 5;
    localparam int CNT_W    = 6;
    localparam int ENV_W    = 15;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam int CIDX_LSB   = 0;
    localparam int CVAL_LSB   = CIDX_LSB + CIDX_W;
    localparam int SAMPLE_LSB = CVAL_LSB + COEF_W;

    localparam int ACC_W  = 40;
    localparam int HV_W   = 22;
    localparam int HV_LSB = 15;
    localparam int MUL_W  = HV_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ROOT_W = 30;
    localparam int RES_W  = ROOT_W;
    localparam int BIT_W  = ROOT_W - 1;

    localparam logic [HALF_W-1:0] HALF_RST  = 5'd15;
    localparam logic [CNT_W-1:0]  WARM_MAX  = 6'd63;
    localparam logic [ENV_W-1:0]  ENV_MAX   = 15'h7fff;
    localparam logic [ACC_W-1:0]  ROUND_ADD = 40'h0000004000;

    localparam logic ACT_COEF   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/hilbert_fir_envelope.sv =====
// Hilbert FIR envelope detector: a shared multiply-accumulate, square and
// integer square root under one sequencer. Depends on hfe_pkg and assert_macros.svh.
//
// Usage: the slave channel carries one request per item. s_tuser selects the
// kind: a coefficient load writes coef_value to tap coef_index,
// a sample enters the circular delay line. s_tlast marks the last sample of a
// scanline. Each sample with at least H earlier samples in the line gives one
// envelope value for the sample H positions back; the line-end sample then
// flushes the remaining values, oldest first, with m_tlast on the final one.
// Every result passes through the 2H+1 taps of the one multiplier, the pipeline
// drain, the squaring steps, fifteen square root iterations and the output
// register; a sample that gives no result leaves the sequencer in its idle
// state. s_tready is high only while the sequencer is idle.
// half_length is written on the cfg channel, which is always ready; write it
// only while the block is idle. Reset clears the control state, sets
// half_length to 15 and marks the delay line empty; coefficients must be loaded.
// A stalled receiver holds the result in the output register and the
// sequencer waits before placing the next one there.
`default_nettype none
`include "assert_macros.svh"

module hilbert_fir_envelope
    import hfe_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // coef_index [5:0], coef_value [21:6], sample_value [37:22], zero fill [39:38]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  wire logic                 s_tuser,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // envelope [14:0], zero fill [15]
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [HALF_W-1:0]    cfg_data
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = ((AW > 7) ? AW : 7) + 1;
    localparam int HALF_LIM = (MAX_TAPS - 1) / 2;
    localparam logic [HALF_W-1:0] HALF_CAP = (HALF_LIM > 31) ? 5'd31 : HALF_W'(HALF_LIM);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SQ,
        ST_ROOT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [AW-1:0]        wp_reg, wp_next;
    logic [HALF_W-1:0]    half_reg, half_next;
    logic                 p1_live_reg, p1_live_next;
    logic                 p2_live_reg, p2_live_next;
    logic                 issued_reg, issued_next;

    logic [HALF_W-1:0]    k_reg, k_next;
    logic [HALF_W-1:0]    h_reg, h_next;
    logic                 end_reg, end_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic                 p1_inwin_reg, p1_inwin_next;
    logic                 p1_center_reg, p1_center_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [SAMPLE_W-1:0]  x_reg, x_next;
    logic [1:0]           sq_step_reg, sq_step_next;
    logic [PROD_W-1:0]    sumsq_reg, sumsq_next;
    logic [ROOT_W-1:0]    rem_reg, rem_next;
    logic [RES_W-1:0]     res_reg, res_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic                 sat_reg, sat_next;
    logic [ENV_W-1:0]     m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    logic [COEF_W-1:0]    coef_mem [MAX_TAPS];
    logic [SAMPLE_W-1:0]  dly_mem  [MAX_TAPS];
    logic [COEF_W-1:0]    coef_q;
    logic [SAMPLE_W-1:0]  dly_q;

    logic                 in_take;
    logic                 coef_we;
    logic                 dly_we;
    logic [CW-1:0]        ci_ext;
    logic [AW-1:0]        wp_inc;
    logic [HALF_W-1:0]    h_eff;
    logic                 issuing;
    logic [7:0]           idx;
    logic [CW-1:0]        dly_diff;
    logic [AW-1:0]        dly_raddr;
    logic [CW-1:0]        j_ext;
    logic [AW-1:0]        coef_raddr;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [ACC_W-1:0]     acc_rnd;
    logic signed [HV_W-1:0] hv;
    logic [PROD_W-1:0]    total;
    logic [ROOT_W:0]      trial;
    logic                 out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, m_data_reg};
    assign m_tlast   = m_last_reg;

    assign in_take  = s_tvalid && s_tready;
    assign ci_ext   = CW'(s_tdata[CIDX_LSB +: CIDX_W]);
    assign coef_we  = in_take && (s_tuser == ACT_COEF) && (ci_ext < CW'(MAX_TAPS));
    assign dly_we   = in_take && (s_tuser == ACT_SAMPLE);
    assign wp_inc   = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;
    assign h_eff    = (half_reg > HALF_CAP) ? HALF_CAP : half_reg;

    assign issuing    = (state_reg == ST_MAC) && !issued_reg;
    assign idx        = 8'(k_reg) + 8'(h_reg) - 8'(j_reg);
    assign dly_diff   = (CW'(wp_reg) - CW'(idx[6:0]));
    assign dly_raddr  = dly_diff[CW-1] ? AW'(dly_diff + CW'(MAX_TAPS)) : dly_diff[AW-1:0];
    assign j_ext      = CW'(j_reg);
    assign coef_raddr = j_ext[AW-1:0];

    assign acc_rnd  = acc_reg + ROUND_ADD;
    assign hv       = acc_rnd[HV_LSB +: HV_W];
    assign total    = sumsq_reg + $unsigned(prod_reg);
    assign trial    = {1'b0, res_reg} + (ROOT_W + 1)'(bit_reg);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        mul_a = {{(MUL_W - COEF_W){coef_q[COEF_W-1]}}, coef_q};
        mul_b = p1_inwin_reg ? {{(MUL_W - SAMPLE_W){dly_q[SAMPLE_W-1]}}, dly_q} : '0;
        if (state_reg == ST_SQ) begin
            if (sq_step_reg == 2'd0) begin
                mul_a = {{(MUL_W - SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
                mul_b = mul_a;
            end else begin
                mul_a = hv;
                mul_b = hv;
            end
        end
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[ci_ext[AW-1:0]] <= s_tdata[CVAL_LSB +: COEF_W];
        end
        coef_q <= coef_mem[coef_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dly_we) begin
            dly_mem[wp_inc] <= s_tdata[SAMPLE_LSB +: SAMPLE_W];
        end
        dly_q <= dly_mem[dly_raddr];
    end

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        count_next     = count_reg;
        wp_next        = wp_reg;
        half_next      = cfg_valid ? cfg_data : half_reg;
        p1_live_next   = issuing;
        p2_live_next   = p1_live_reg;
        issued_next    = issued_reg;
        k_next         = k_reg;
        h_next         = h_reg;
        end_next       = end_reg;
        j_next         = j_reg;
        p1_inwin_next  = !idx[7] && (idx[6:0] < 7'(count_reg));
        p1_center_next = (j_reg == 6'(h_reg));
        acc_next       = acc_reg;
        prod_next      = mul_p;
        x_next         = x_reg;
        sq_step_next   = sq_step_reg;
        sumsq_next     = sumsq_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        sat_next       = sat_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (dly_we) begin
                    wp_next     = wp_inc;
                    count_next  = (count_reg == WARM_MAX) ? WARM_MAX : count_reg + 1'b1;
                    h_next      = h_eff;
                    end_next    = s_tlast;
                    j_next      = '0;
                    issued_next = 1'b0;
                    acc_next    = '0;
                    if (count_reg >= 6'(h_eff)) begin
                        k_next     = h_eff;
                        state_next = ST_MAC;
                    end else if (s_tlast) begin
                        k_next     = count_reg[HALF_W-1:0];
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (issuing) begin
                    j_next = j_reg + 1'b1;
                    if (j_reg == {h_reg, 1'b0}) begin
                        issued_next = 1'b1;
                    end
                end
                if (p1_live_reg && p1_center_reg) begin
                    x_next = p1_inwin_reg ? dly_q : '0;
                end
                if (p2_live_reg) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (issued_reg && !p1_live_reg && !p2_live_reg) begin
                    sq_step_next = 2'd0;
                    state_next   = ST_SQ;
                end
            end
            ST_SQ: begin
                sq_step_next = sq_step_reg + 1'b1;
                if (sq_step_reg == 2'd1) begin
                    sumsq_next = $unsigned(prod_reg);
                end else if (sq_step_reg == 2'd2) begin
                    rem_next   = total[ROOT_W-1:0];
                    sat_next   = |total[PROD_W-1:ROOT_W];
                    res_next   = '0;
                    bit_next   = {1'b1, {(BIT_W - 1){1'b0}}};
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if ({1'b0, rem_reg} >= trial) begin
                    rem_next = rem_reg - trial[ROOT_W-1:0];
                    res_next = (res_reg >> 1) + RES_W'(bit_reg);
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = sat_reg ? ENV_MAX : res_reg[ENV_W-1:0];
                    m_last_next  = end_reg && (k_reg == '0);
                    if (end_reg && (k_reg != '0)) begin
                        k_next      = k_reg - 1'b1;
                        j_next      = '0;
                        issued_next = 1'b0;
                        acc_next    = '0;
                        state_next  = ST_MAC;
                    end else begin
                        if (end_reg) begin
                            count_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            wp_reg      <= '0;
            half_reg    <= HALF_RST;
            p1_live_reg <= 1'b0;
            p2_live_reg <= 1'b0;
            issued_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            wp_reg      <= wp_next;
            half_reg    <= half_next;
            p1_live_reg <= p1_live_next;
            p2_live_reg <= p2_live_next;
            issued_reg  <= issued_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        h_reg         <= h_next;
        end_reg       <= end_next;
        j_reg         <= j_next;
        p1_inwin_reg  <= p1_inwin_next;
        p1_center_reg <= p1_center_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        x_reg         <= x_next;
        sq_step_reg   <= sq_step_next;
        sumsq_reg     <= sumsq_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        bit_reg       <= bit_next;
        sat_reg       <= sat_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    `HFE_NEVER(a_mac_pipe_idle, aclk, aresetn, (state_reg != ST_MAC) && (p1_live_reg || p2_live_reg))
    `HFE_ASSERT(a_tap_in_range, aclk, aresetn, issuing |-> (j_reg <= {h_reg, 1'b0}))
    `HFE_ASSERT(a_root_bit_onehot, aclk, aresetn, (state_reg == ST_ROOT) |-> $onehot(bit_reg))
    `HFE_ASSERT(a_result_from_out, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))

endmodule

`default_nettype wire
